// ===== hdl/rld_pkg.sv =====
// Shared types and constants for the run-list decoder.
`default_nettype none

package rld_pkg;

  // Status codes on the result channel. Code 2 (buffer end) is reserved.
  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_OVERSIZE = 3'd4;

  // Parser phases.
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_COUNT  = 2'd1;
  localparam logic [1:0] PH_OFFSET = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Queue depths between the parts.
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_RUN,
    CMD_END
  } cmd_kind_e;

  // Request from the parser to the run builder.
  typedef struct packed {
    logic        clear_prev;
    cmd_kind_e   kind;
    logic [2:0]  status;
    logic        done;
    logic [63:0] clusters;
    logic [63:0] offset;
  } cmd_t;

  // One decoded result.
  typedef struct packed {
    logic [63:0] start;
    logic [63:0] clusters;
    logic [2:0]  status;
    logic        done;
  } res_t;

  // Sign-extend a little-endian field of n bytes; n of zero gives zero.
  function automatic logic [63:0] rld_sext(logic [63:0] v, logic [3:0] n);
    logic        s;
    logic [63:0] r;
    s = 1'b0;
    r = '0;
    for (int i = 1; i <= 8; i++) begin
      if (n == 4'(i)) begin
        s = v[8*i-1];
      end
    end
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = (4'(i) < n) ? v[8*i +: 8] : {8{s}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/runlist_decoder.sv =====
// Top level of the streaming data-run list decoder.
//
// Usage:
//   Input queue side: drive list_byte_i, first_of_list_i, last_of_buffer_i and
//   raise push; a byte request is taken at a clock edge with push high and
//   full low. Mark the first header byte of every list with first_of_list_i
//   and the final byte of the buffer with last_of_buffer_i.
//   Result queue side: while empty is low the oldest result sits on
//   run_start_o, run_clusters_o, status_o and list_done_o; pop it by raising
//   pop. A result is produced when a run completes or the list ends.
// Throughput: one byte per cycle sustained while full stays low; the parser
//   state update is a registered loop and the 64-bit start add runs once per request.
// Path: a byte that completes a run goes through the parser into the request
//   queue, then through the run builder into the result queue, and then sits on
//   the result ports; a full result queue holds it back in the request queue.
// Reset: both queues empty, parser expects a header, previous start is zero.
// Stall: when pop is held low the result queue fills, the run builder holds,
//   the request queue fills, and full rises; nothing is lost.
`default_nettype none

module runlist_decoder #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input queue
  input  wire logic         push,
  output logic              full,
  input  wire logic [7:0]   list_byte_i,
  input  wire logic         first_of_list_i,
  input  wire logic         last_of_buffer_i,
  // result queue
  output logic              empty,
  input  wire logic         pop,
  output logic signed [63:0] run_start_o,
  output logic [63:0]       run_clusters_o,
  output logic [2:0]        status_o,
  output logic              list_done_o
);
  import rld_pkg::*;

  logic  accept;
  logic  cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic  res_push, res_full;
  cmd_t  cmd_in, cmd_head;
  res_t  res_in, res_head;

  // Take a byte whenever the request queue has room.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // Front: classify each byte and issue requests.
  rld_front #(
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .list_byte_i (list_byte_i),
    .first_i     (first_of_list_i),
    .last_i      (last_of_buffer_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  // Decouple parser from run builder.
  rld_fifo #(
    .DEPTH   (CMD_DEPTH),
    .entry_t (cmd_t)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  // Back: resolve absolute starts and form results.
  rld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Hold results until the receiver pops them.
  rld_fifo #(
    .DEPTH   (RES_DEPTH),
    .entry_t (res_t)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_head),
    .empty_o (empty)
  );

  assign run_start_o    = signed'(res_head.start);
  assign run_clusters_o = res_head.clusters;
  assign status_o       = res_head.status;
  assign list_done_o    = res_head.done;

endmodule

`default_nettype wire

// ===== hdl/rld_fifo.sv =====
// Small register queue with count-based full and empty flags.
`default_nettype none

module rld_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type         entry_t = logic
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  entry_t      wdata_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output entry_t      rdata_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rld_front.sv =====
// Byte parser: tracks header and field phases, gathers fields, issues requests.
`default_nettype none

module rld_front #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   list_byte_i,
  input  wire logic         first_i,
  input  wire logic         last_i,
  output logic              cmd_push_o,
  output rld_pkg::cmd_t     cmd_o
);
  import rld_pkg::*;

  logic [1:0]  phase_q, phase_d, phase_eff;
  logic [3:0]  bytes_left_q, bytes_left_d, bl_dec;
  logic [3:0]  off_size_q, off_size_d;
  logic [2:0]  pos_q, pos_d;
  logic [63:0] cnt_acc_q, cnt_acc_d, off_acc_q, off_acc_d;
  logic [63:0] byte_sh, cnt_new, off_new;
  logic [3:0]  len_nib, off_nib;
  cmd_t        cmd;

  assign len_nib   = list_byte_i[3:0];
  assign off_nib   = list_byte_i[7:4];
  assign phase_eff = first_i ? PH_HEADER : phase_q;
  assign byte_sh   = {56'd0, list_byte_i} << {pos_q, 3'b000};
  assign cnt_new   = cnt_acc_q | byte_sh;
  assign off_new   = off_acc_q | byte_sh;
  assign bl_dec    = bytes_left_q - 4'd1;

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    off_size_d   = off_size_q;
    pos_d        = pos_q;
    cnt_acc_d    = cnt_acc_q;
    off_acc_d    = off_acc_q;
    cmd            = '0;
    cmd.clear_prev = first_i;
    cmd.kind       = CMD_NONE;
    if (accept_i) begin
      case (phase_eff)
        PH_HEADER: begin
          if (list_byte_i == 8'd0) begin
            cmd.kind = CMD_END; cmd.status = ST_ZERO; cmd.done = 1'b1;
            phase_d  = PH_DONE;
          end else if (len_nib > 4'(MAX_FIELD_BYTES) || off_nib > 4'(MAX_FIELD_BYTES)) begin
            cmd.kind = CMD_END; cmd.status = ST_OVERSIZE; cmd.done = 1'b1;
            phase_d  = PH_DONE;
          end else if (last_i) begin
            cmd.kind = CMD_END; cmd.status = ST_TRUNC; cmd.done = 1'b1;
            phase_d  = PH_DONE;
          end else begin
            cnt_acc_d  = '0;
            off_acc_d  = '0;
            pos_d      = '0;
            off_size_d = off_nib;
            if (len_nib != 4'd0) begin
              phase_d      = PH_COUNT;
              bytes_left_d = len_nib;
            end else begin
              phase_d      = PH_OFFSET;
              bytes_left_d = off_nib;
            end
          end
        end
        PH_COUNT: begin
          cnt_acc_d    = cnt_new;
          pos_d        = pos_q + 3'd1;
          bytes_left_d = bl_dec;
          if (bl_dec == 4'd0 && off_size_q == 4'd0) begin
            cmd.kind     = CMD_RUN; cmd.status = ST_RUN; cmd.done = last_i;
            cmd.clusters = cnt_new;
            cmd.offset   = '0;
            phase_d      = last_i ? PH_DONE : PH_HEADER;
          end else if (last_i) begin
            cmd.kind = CMD_END; cmd.status = ST_TRUNC; cmd.done = 1'b1;
            phase_d  = PH_DONE;
          end else if (bl_dec == 4'd0) begin
            phase_d      = PH_OFFSET;
            bytes_left_d = off_size_q;
            pos_d        = '0;
          end
        end
        PH_OFFSET: begin
          off_acc_d    = off_new;
          pos_d        = pos_q + 3'd1;
          bytes_left_d = bl_dec;
          if (bl_dec == 4'd0) begin
            cmd.kind     = CMD_RUN; cmd.status = ST_RUN; cmd.done = last_i;
            cmd.clusters = cnt_acc_q;
            cmd.offset   = rld_sext(off_new, off_size_q);
            phase_d      = last_i ? PH_DONE : PH_HEADER;
          end else if (last_i) begin
            cmd.kind = CMD_END; cmd.status = ST_TRUNC; cmd.done = 1'b1;
            phase_d  = PH_DONE;
          end
        end
        default: begin
          // list ended: drop bytes until the next list starts
        end
      endcase
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept_i && (first_i || cmd.kind != CMD_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      bytes_left_q <= '0;
      off_size_q   <= '0;
      pos_q        <= '0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      off_size_q   <= off_size_d;
      pos_q        <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_acc_q <= cnt_acc_d;
    off_acc_q <= off_acc_d;
  end

endmodule

`default_nettype wire

// ===== hdl/rld_back.sv =====
// Run builder: applies requests, adds relative starts, forms results.
`default_nettype none

module rld_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  rld_pkg::cmd_t     cmd_i,
  input  wire logic         cmd_empty_i,
  output logic              cmd_pop_o,
  input  wire logic         res_full_i,
  output logic              res_push_o,
  output rld_pkg::res_t     res_o
);
  import rld_pkg::*;

  logic [63:0] prev_q, prev_d, base, start;
  logic        take;

  assign cmd_pop_o  = !cmd_empty_i && (cmd_i.kind == CMD_NONE || !res_full_i);
  assign take       = cmd_pop_o;
  assign res_push_o = take && (cmd_i.kind != CMD_NONE);
  assign base       = cmd_i.clear_prev ? 64'd0 : prev_q;
  assign start      = base + cmd_i.offset;

  always_comb begin
    prev_d       = prev_q;
    res_o.start    = '0;
    res_o.clusters = '0;
    res_o.status   = cmd_i.status;
    res_o.done     = cmd_i.done;
    if (take) begin
      prev_d = base;
      if (cmd_i.kind == CMD_RUN) begin
        prev_d         = start;
        res_o.start    = start;
        res_o.clusters = cmd_i.clusters;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

`default_nettype wire

// ===== test/runlist_decoder_tb.sv =====
// Self-checking testbench for the run-list decoder: queue-style driver and monitor.
`timescale 1ns / 100ps

module runlist_decoder_tb;
  import rld_pkg::*;

  localparam int unsigned MAX_FIELD_BYTES = 8;

  // One byte request as the sender offers it, with the idle cycles it waits first.
  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic        last;
    int unsigned gap;
  } byte_req_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                push             = 1'b0;
  logic [7:0]          list_byte_i      = 8'h00;
  logic                first_of_list_i  = 1'b0;
  logic                last_of_buffer_i = 1'b0;
  logic                pop              = 1'b0;
  logic                full;
  logic                empty;
  logic signed [63:0]  run_start_o;
  logic [63:0]         run_clusters_o;
  logic [2:0]          status_o;
  logic                list_done_o;

  // Stimulus queue, expected results and error count.
  byte_req_t   byte_queue[$];
  res_t        expected_runs[$];
  int unsigned queued_items = 0;
  int unsigned mismatches   = 0;

  // Knobs for the idle pattern on each side, set between phases.
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned hold_tag = 0;
  int unsigned hold_len = 0;

  // Driver and monitor bookkeeping.
  int unsigned tx_wait     = 0;
  bit          head_gapped = 1'b0;
  int unsigned rx_wait     = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_seen   = 0;

  // Decoder state mirrored by the predictor.
  logic [1:0]  scan_phase       = PH_HEADER;
  logic [3:0]  field_bytes_left = '0;
  logic [3:0]  offset_bytes     = '0;
  logic [2:0]  shift_slot       = '0;
  logic [63:0] cluster_acc      = '0;
  logic [63:0] delta_acc        = '0;
  logic [63:0] last_start       = '0;

  runlist_decoder #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .list_byte_i     (list_byte_i),
    .first_of_list_i (first_of_list_i),
    .last_of_buffer_i(last_of_buffer_i),
    .empty           (empty),
    .pop             (pop),
    .run_start_o     (run_start_o),
    .run_clusters_o  (run_clusters_o),
    .status_o        (status_o),
    .list_done_o     (list_done_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sign-extend a relative start of n bytes to 64 bits; a zero-size field is zero.
  function automatic logic [63:0] widen_offset(logic [63:0] v, logic [3:0] n);
    logic [63:0] mask;
    if (n == 4'd0) return '0;
    if (n >= 4'd8) return v;
    mask = {64{1'b1}} << (n * 8);
    return v[n * 8 - 1] ? (v | mask) : v;
  endfunction

  // Record one expected result; a list-ending result parks the parser until the next list.
  task automatic post_run(logic [63:0] start, logic [63:0] clusters, logic [2:0] status,
                          logic done);
    res_t r;
    r.start    = start;
    r.clusters = clusters;
    r.status   = status;
    r.done     = done;
    expected_runs = {expected_runs, r};
    if (done) scan_phase = PH_DONE;
  endtask

  // Complete the current run: a sparse run keeps the previous start.
  task automatic close_run(logic last);
    logic [63:0] start;
    start = last_start;
    if (offset_bytes != 4'd0) start = last_start + widen_offset(delta_acc, offset_bytes);
    last_start = start;
    scan_phase = PH_HEADER;
    post_run(start, cluster_acc, ST_RUN, last);
  endtask

  // Advance the mirrored parser by one accepted byte request.
  task automatic parse_list_byte(logic [7:0] b, logic first, logic last);
    logic [3:0] len_nib;
    logic [3:0] off_nib;
    len_nib = b[3:0];
    off_nib = b[7:4];
    if (first) begin
      last_start = '0;
      scan_phase = PH_HEADER;
    end
    case (scan_phase)
      PH_DONE: ;
      PH_HEADER: begin
        if (b == 8'h00) begin
          post_run('0, '0, ST_ZERO, 1'b1);
        end else if (len_nib > MAX_FIELD_BYTES || off_nib > MAX_FIELD_BYTES) begin
          post_run('0, '0, ST_OVERSIZE, 1'b1);
        end else if (last) begin
          post_run('0, '0, ST_TRUNC, 1'b1);
        end else begin
          cluster_acc  = '0;
          delta_acc    = '0;
          shift_slot   = '0;
          offset_bytes = off_nib;
          if (len_nib != 4'd0) begin
            scan_phase       = PH_COUNT;
            field_bytes_left = len_nib;
          end else begin
            scan_phase       = PH_OFFSET;
            field_bytes_left = off_nib;
          end
        end
      end
      PH_COUNT: begin
        cluster_acc      = cluster_acc | (64'(b) << {shift_slot, 3'b000});
        shift_slot       = shift_slot + 3'd1;
        field_bytes_left = field_bytes_left - 4'd1;
        if (field_bytes_left == 4'd0) begin
          if (offset_bytes == 4'd0) begin
            close_run(last);
          end else if (last) begin
            post_run('0, '0, ST_TRUNC, 1'b1);
          end else begin
            scan_phase       = PH_OFFSET;
            field_bytes_left = offset_bytes;
            shift_slot       = '0;
          end
        end else if (last) begin
          post_run('0, '0, ST_TRUNC, 1'b1);
        end
      end
      default: begin
        delta_acc        = delta_acc | (64'(b) << {shift_slot, 3'b000});
        shift_slot       = shift_slot + 3'd1;
        field_bytes_left = field_bytes_left - 4'd1;
        if (field_bytes_left == 4'd0) begin
          close_run(last);
        end else if (last) begin
          post_run('0, '0, ST_TRUNC, 1'b1);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer byte requests from the queue, predict each one as it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : tx_side
    byte_req_t nxt;
    if (!rst_ni) begin
      push             <= 1'b0;
      list_byte_i      <= 8'h00;
      first_of_list_i  <= 1'b0;
      last_of_buffer_i <= 1'b0;
    end else begin
      // A request is taken on this edge: run it through the predictor.
      if (push && !full) parse_list_byte(list_byte_i, first_of_list_i, last_of_buffer_i);
      // Hold the current request while full blocks it; otherwise pick the next one.
      if (!push || !full) begin
        if (byte_queue.size() == 0) begin
          push <= 1'b0;
        end else begin
          // Load the idle gap once per request, then count it down.
          if (!head_gapped) begin
            tx_wait     = byte_queue[0].gap;
            head_gapped = 1'b1;
          end
          if (tx_wait != 0) begin
            tx_wait--;
            push <= 1'b0;
          end else begin
            nxt              = byte_queue.pop_front();
            head_gapped      = 1'b0;
            list_byte_i      <= nxt.data;
            first_of_list_i  <= nxt.first;
            last_of_buffer_i <= nxt.last;
            push             <= 1'b1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: pop results with random gaps and compare against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : rx_side
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_runs.size() == 0) begin
          report_mismatch("result with no run expected", run_start_o, '0);
        end else begin
          want = expected_runs.pop_front();
          if (run_start_o !== want.start)
            report_mismatch("run_start", run_start_o, want.start);
          if (run_clusters_o !== want.clusters)
            report_mismatch("run_clusters", run_clusters_o, want.clusters);
          if (status_o !== want.status)
            report_mismatch("status", 64'(status_o), 64'(want.status));
          if (list_done_o !== want.done)
            report_mismatch("list_done", 64'(list_done_o), 64'(want.done));
        end
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 3);
      end
      // Start a long hold-off when the stimulus asks for one.
      if (hold_tag != hold_seen) begin
        hold_seen = hold_tag;
        hold_left = hold_len;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_byte(logic [7:0] data, logic first, logic last, bit counted);
    byte_req_t r;
    r.data  = data;
    r.first = first;
    r.last  = last;
    r.gap   = tx_quiet ? 0 : $urandom_range(0, 3);
    byte_queue = {byte_queue, r};
    if (counted) queued_items++;
  endtask

  // Field bytes lean to the extremes now and then.
  function automatic logic [7:0] random_data();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // Mostly short fields, some sparse, a few up to the full eight bytes.
  function automatic int unsigned pick_field_size();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 10) return $urandom_range(1, 3);
    if (r < 13) return 0;
    return $urandom_range(4, MAX_FIELD_BYTES);
  endfunction

  // Queue one list: well-formed runs with random content, ended by a zero header, by
  // the buffer end, by a cut-off run or by an oversize header; or plain noise.
  task automatic queue_random_list();
    int unsigned runs;
    int unsigned kind;
    int unsigned len_sz;
    int unsigned off_sz;
    int unsigned total;
    int          last_at;
    logic [7:0]  hdr;
    bit          stop;
    runs = $urandom_range(1, 4);
    kind = $urandom_range(0, 9);
    stop = 1'b0;
    if (kind == 9) begin
      // Noise: random bytes with random list marks.
      repeat ($urandom_range(1, 10))
        queue_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0, 1'b1);
    end else begin
      for (int r = 0; r < runs && !stop; r++) begin
        len_sz = pick_field_size();
        off_sz = pick_field_size();
        if (len_sz == 0 && off_sz == 0) len_sz = 1;
        hdr     = {4'(off_sz), 4'(len_sz)};
        total   = 1 + len_sz + off_sz;
        last_at = -1;
        if (r == runs - 1) begin
          if (kind == 4 || kind == 5) last_at = total - 1;
          else if (kind == 6 || kind == 7) last_at = $urandom_range(0, total - 2);
        end
        for (int i = 0; i < total && !stop; i++) begin
          queue_byte((i == 0) ? hdr : random_data(), r == 0 && i == 0, i == last_at, 1'b1);
          if (i == last_at) stop = 1'b1;
        end
      end
      if (kind <= 3) begin
        queue_byte(8'h00, 1'b0, $urandom_range(0, 2) == 0, 1'b1);
      end else if (kind == 8) begin
        if ($urandom_range(0, 1))
          hdr = {4'($urandom_range(9, 15)), 4'($urandom_range(0, 15))};
        else
          hdr = {4'($urandom_range(0, 15)), 4'($urandom_range(9, 15))};
        queue_byte(hdr, 1'b0, $urandom_range(0, 1), 1'b1);
      end
      // Trailing bytes after the list end are dropped by the block.
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2))
          queue_byte(random_data(), 1'b0, $urandom_range(0, 1), 1'b0);
    end
  endtask

  task automatic queue_random_items(int unsigned count);
    int unsigned goal;
    goal = queued_items + count;
    while (queued_items < goal) queue_random_list();
  endtask

  // Block until every request is taken and every expected result has been popped.
  task automatic wait_drained();
    while (byte_queue.size() != 0 || push || expected_runs.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: first list without a first-of-list mark, negative start, full count byte.
    queue_byte(8'h11, 1'b0, 1'b0, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b0, 1'b1);
    queue_byte(8'h80, 1'b0, 1'b0, 1'b1);
    // Sparse run keeps the start, then a zero header ends the list.
    queue_byte(8'h01, 1'b0, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b0, 1'b1);
    // Dropped after list end.
    queue_byte(8'h21, 1'b0, 1'b0, 1'b0);
    // Oversize count field, oversize offset field.
    queue_byte(8'h09, 1'b1, 1'b0, 1'b1);
    queue_byte(8'h90, 1'b1, 1'b0, 1'b1);
    // Header on the last byte: truncated, zero terminator, oversize wins.
    queue_byte(8'h11, 1'b1, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b1, 1'b1, 1'b1);
    queue_byte(8'hFF, 1'b1, 1'b1, 1'b1);
    // Buffer ends right after the count field, in the middle of it, inside the offset.
    queue_byte(8'h21, 1'b1, 1'b0, 1'b1);
    queue_byte(8'h07, 1'b0, 1'b1, 1'b1);
    queue_byte(8'h12, 1'b1, 1'b0, 1'b1);
    queue_byte(8'hAA, 1'b0, 1'b1, 1'b1);
    queue_byte(8'h21, 1'b1, 1'b0, 1'b1);
    queue_byte(8'h33, 1'b0, 1'b0, 1'b1);
    queue_byte(8'h44, 1'b0, 1'b1, 1'b1);
    // Offset-only run that completes on the last byte of the buffer.
    queue_byte(8'h10, 1'b1, 1'b0, 1'b1);
    queue_byte(8'h7F, 1'b0, 1'b1, 1'b1);
    wait_drained();

    // Random lists with idle gaps on both sides.
    queue_random_items(350);
    wait_drained();

    // Hold the receiver off while the sender streams without gaps: fill the block up.
    hold_len = 300;
    hold_tag++;
    tx_quiet = 1'b1;
    queue_random_items(80);
    tx_quiet = 1'b0;
    wait_drained();

    // Stretch with no idling on either side.
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    queue_random_items(150);
    wait_drained();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    queue_random_items(370);
    wait_drained();

    // Give the pipeline time to show any stray result.
    repeat (8) @(negedge clk_i);
    if (expected_runs.size() != 0)
      report_mismatch("runs never delivered", 64'(expected_runs.size()), '0);
    if (mismatches == 0) begin
      $display("runlist_decoder_tb OK");
    end else begin
      $display("runlist_decoder_tb NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("runlist_decoder_tb NOT OK");
    $finish;
  end

endmodule

// ===== runlist_decoder.f =====
hdl/rld_pkg.sv
hdl/rld_fifo.sv
hdl/rld_front.sv
hdl/rld_back.sv
hdl/runlist_decoder.sv
test/runlist_decoder_tb.sv
